FILE: rtl/box_to_grid_cell_range_unit_macros.svh
// ----------------------------------------------------------------------------
// box to grid cell range unit assertion macros
// concurrent checks that fall away in synthesis builds
// ----------------------------------------------------------------------------
`ifndef BOX_TO_GRID_CELL_RANGE_UNIT_MACROS_SVH
`define BOX_TO_GRID_CELL_RANGE_UNIT_MACROS_SVH

`ifndef SYNTH
`define BGCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgcr check failed");
`define BGCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgcr check failed");
`else
`define BGCR_ASSERT_IMP(lbl, ante, cons)
`define BGCR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/bgcr_pkg.sv
// ----------------------------------------------------------------------------
// bgcr_pkg
// shared types, constants and helpers of the box to grid cell range unit
// ----------------------------------------------------------------------------
`default_nettype none
package bgcr_pkg;

  localparam int COORD_W          = 32;
  localparam int DIM_W            = 13;
  localparam int IDX_W            = 12;
  localparam int CFG_IDX_W        = 3;
  localparam int DEF_MAX_GRID_DIM = 4096;
  localparam int MAXD_W           = 17;
  localparam int QDEPTH           = 4;
  localparam int QPTR_W           = 2;
  localparam int QCNT_W           = 3;
  localparam int NLANE            = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORLD_LEFT   = 3'd0,
    CFG_WORLD_RIGHT  = 3'd1,
    CFG_WORLD_TOP    = 3'd2,
    CFG_WORLD_BOTTOM = 3'd3,
    CFG_GRID_ROWS    = 3'd4,
    CFG_GRID_COLS    = 3'd5
  } cfg_idx_t;

  // lanes: first row, last row, first col, last col
  localparam int LANE_FIRST_ROW = 0;
  localparam int LANE_LAST_ROW  = 1;
  localparam int LANE_FIRST_COL = 2;
  localparam int LANE_LAST_COL  = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] wl;
    logic signed [COORD_W-1:0] wr;
    logic signed [COORD_W-1:0] wt;
    logic signed [COORD_W-1:0] wb;
    logic [COORD_W-1:0]        h;
    logic [COORD_W-1:0]        w;
    logic [DIM_W-1:0]          nrows;
    logic [DIM_W-1:0]          ncols;
    logic                      bad;
  } world_t;

  typedef struct packed {
    logic                          invalid;
    logic [NLANE-1:0][COORD_W-1:0] off;
  } job_t;

  function automatic logic signed [COORD_W:0] sdiff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
    sdiff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  // negative offsets go to zero, larger ones to the extent
  function automatic logic [COORD_W-1:0] lim(input logic signed [COORD_W:0] d,
                                             input logic [COORD_W-1:0] e);
    if (d[COORD_W])
      lim = '0;
    else if (d[COORD_W-1:0] > e)
      lim = e;
    else
      lim = d[COORD_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] grid_dim(input logic [DIM_W-1:0] v,
                                                input logic [MAXD_W-1:0] maxd);
    logic [MAXD_W-1:0] d;
    d = MAXD_W'(v);
    if (d == '0)
      d = MAXD_W'(1);
    if (d > maxd)
      d = maxd;
    grid_dim = d[DIM_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bgcr_in_if.sv
// ----------------------------------------------------------------------------
// bgcr_in_if
// box channel: valid, ready and the four box edges
// ----------------------------------------------------------------------------
`default_nettype none
interface bgcr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bgcr_pkg::COORD_W-1:0] box_left;
  logic signed [bgcr_pkg::COORD_W-1:0] box_right;
  logic signed [bgcr_pkg::COORD_W-1:0] box_top;
  logic signed [bgcr_pkg::COORD_W-1:0] box_bottom;

  modport source(output valid, box_left, box_right, box_top, box_bottom, input ready);
  modport sink(input valid, box_left, box_right, box_top, box_bottom, output ready);
endinterface
`default_nettype wire

FILE: rtl/bgcr_out_if.sv
// ----------------------------------------------------------------------------
// bgcr_out_if
// result channel: valid, ready and the cell range of one box
// ----------------------------------------------------------------------------
`default_nettype none
interface bgcr_out_if;
  logic                         valid;
  logic                         ready;
  logic [bgcr_pkg::IDX_W-1:0]   first_row;
  logic [bgcr_pkg::IDX_W-1:0]   last_row;
  logic [bgcr_pkg::IDX_W-1:0]   first_col;
  logic [bgcr_pkg::IDX_W-1:0]   last_col;
  logic                         world_invalid;

  modport source(output valid, first_row, last_row, first_col, last_col, world_invalid,
                 input ready);
  modport sink(input valid, first_row, last_row, first_col, last_col, world_invalid,
               output ready);
endinterface
`default_nettype wire

FILE: rtl/bgcr_front.sv
// ----------------------------------------------------------------------------
// bgcr_front
// accepts boxes, clamps them to the world and forms the top, bottom, left and right edge offsets
// ----------------------------------------------------------------------------
`default_nettype none
module bgcr_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  bgcr_in_if.sink             in_box,
  input  wire bgcr_pkg::world_t world,
  input  wire logic           q_full,
  output logic                job_valid,
  output bgcr_pkg::job_t      job
);
  import bgcr_pkg::*;

  logic            fv_r, fv_nxt;
  job_t            job_r, job_nxt;
  logic            take;
  logic signed [COORD_W-1:0] bt_c, bb_c, bl_c, br_c;

  assign in_box.ready = !fv_r || !q_full;
  assign take         = in_box.valid && in_box.ready;

  always_comb begin
    bt_c = (in_box.box_top > world.wt) ? world.wt : in_box.box_top;
    bb_c = (in_box.box_bottom < world.wb) ? world.wb : in_box.box_bottom;
    bl_c = (in_box.box_left < world.wl) ? world.wl : in_box.box_left;
    br_c = (in_box.box_right > world.wr) ? world.wr : in_box.box_right;
    job_nxt.invalid             = world.bad;
    job_nxt.off[LANE_FIRST_ROW] = lim(sdiff(world.wt, bt_c), world.h);
    job_nxt.off[LANE_LAST_ROW]  = lim(sdiff(world.wt, bb_c), world.h);
    job_nxt.off[LANE_FIRST_COL] = lim(sdiff(bl_c, world.wl), world.w);
    job_nxt.off[LANE_LAST_COL]  = lim(sdiff(br_c, world.wl), world.w);
    fv_nxt = take ? 1'b1 : (fv_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = fv_r;
  assign job       = job_r;
endmodule
`default_nettype wire

FILE: rtl/bgcr_queue.sv
// ----------------------------------------------------------------------------
// bgcr_queue
// short queue between the front and the back part
// ----------------------------------------------------------------------------
`default_nettype none
module bgcr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bgcr_pkg::job_t push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                nempty,
  output bgcr_pkg::job_t      head,
  output logic [bgcr_pkg::QCNT_W-1:0] cnt
);
  import bgcr_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  assign full   = (cnt_r == QCNT_W'(QDEPTH));
  assign nempty = (cnt_r != '0);
  assign head   = mem[rp_r];
  assign cnt    = cnt_r;
endmodule
`default_nettype wire

FILE: rtl/bgcr_back.sv
// ----------------------------------------------------------------------------
// bgcr_back
// scales offsets by the grid size and divides by the extent, one quotient
// bit per stage, then forms floor or ceil-1 indices and clamps them
// ----------------------------------------------------------------------------
`default_nettype none
module bgcr_back #(
  parameter int MAX_GRID_DIM = bgcr_pkg::DEF_MAX_GRID_DIM
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_valid,
  input  wire bgcr_pkg::job_t   job,
  input  wire bgcr_pkg::world_t world,
  output logic                  pop,
  bgcr_out_if.source            out_res
);
  import bgcr_pkg::*;

  localparam int QW = $clog2(MAX_GRID_DIM + 1);
  localparam int RW = COORD_W + DIM_W;
  localparam int SW = RW + QW;
  localparam int VW = (QW + 1 > DIM_W + 1) ? QW + 1 : DIM_W + 1;

  logic                          adv;
  logic [QW:0]                   sv_r;
  logic                          inv_r [QW+1];
  logic [NLANE-1:0][RW-1:0]      rem_r [QW+1];
  logic [NLANE-1:0][QW-1:0]      quo_r [QW+1];

  logic                          ov_r;
  logic                          oinv_r;
  logic [NLANE-1:0][IDX_W-1:0]   oidx_r, oidx_nxt;

  // whole pipeline moves unless a finished beat waits at the output
  assign adv = !ov_r || out_res.ready;
  assign pop = adv && job_valid;

  function automatic logic [COORD_W-1:0] ext_of(input int lane, input world_t wd);
    ext_of = (lane < LANE_FIRST_COL) ? wd.h : wd.w;
  endfunction

  function automatic logic [DIM_W-1:0] dim_of(input int lane, input world_t wd);
    dim_of = (lane < LANE_FIRST_COL) ? wd.nrows : wd.ncols;
  endfunction

  // multiply stage
  always_ff @(posedge clk) begin
    if (adv) begin
      inv_r[0] <= job.invalid;
      for (int i = 0; i < NLANE; i++) begin
        rem_r[0][i] <= RW'(job.off[i]) * RW'(dim_of(i, world));
        quo_r[0][i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (adv) begin
      sv_r <= {sv_r[QW-1:0], job_valid};
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_div
    localparam int K = QW - s;
    logic [NLANE-1:0][RW-1:0] rem_nxt;
    logic [NLANE-1:0][QW-1:0] quo_nxt;

    always_comb begin
      logic [SW-1:0] dsh;
      logic [SW-1:0] rx;
      for (int i = 0; i < NLANE; i++) begin
        dsh        = SW'(ext_of(i, world)) << K;
        rx         = SW'(rem_r[s-1][i]);
        quo_nxt[i] = quo_r[s-1][i];
        if (rx >= dsh) begin
          rem_nxt[i]    = RW'(rx - dsh);
          quo_nxt[i][K] = 1'b1;
        end else begin
          rem_nxt[i] = rem_r[s-1][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        inv_r[s] <= inv_r[s-1];
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  always_comb begin
    logic [VW-1:0] v;
    logic [VW-1:0] n;
    for (int i = 0; i < NLANE; i++) begin
      n = VW'(dim_of(i, world));
      v = VW'(quo_r[QW][i]);
      if (i == LANE_LAST_ROW || i == LANE_LAST_COL) begin
        // ceil minus one: floor when inexact, floor-1 when exact
        if (rem_r[QW][i] == '0)
          v = (v == '0) ? '0 : v - VW'(1);
      end
      if (v >= n)
        v = n - VW'(1);
      oidx_nxt[i] = inv_r[QW] ? '0 : v[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= sv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oinv_r <= inv_r[QW];
      oidx_r <= oidx_nxt;
    end
  end

  assign out_res.valid         = ov_r;
  assign out_res.first_row     = oidx_r[LANE_FIRST_ROW];
  assign out_res.last_row      = oidx_r[LANE_LAST_ROW];
  assign out_res.first_col     = oidx_r[LANE_FIRST_COL];
  assign out_res.last_col      = oidx_r[LANE_LAST_COL];
  assign out_res.world_invalid = oinv_r;
endmodule
`default_nettype wire

FILE: rtl/box_to_grid_cell_range_unit.sv
// throughput: one box per cycle, set by the bit-per-stage divider pipeline
// the pipeline stalls as a whole only while a result beat waits at the output
// reset: synchronous active-low rst_n clears all valid state and sets the
// world to 0..1.0 on both axes with a single row and column
`default_nettype none
`include "box_to_grid_cell_range_unit_macros.svh"
// ----------------------------------------------------------------------------
// box_to_grid_cell_range_unit
// maps one axis-aligned box onto the row and column range of a uniform grid
// ----------------------------------------------------------------------------
module box_to_grid_cell_range_unit #(
  parameter int MAX_GRID_DIM = bgcr_pkg::DEF_MAX_GRID_DIM
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bgcr_in_if.sink                               in_box,
  bgcr_out_if.source                            out_res,
  input  wire logic                             cfg_we,
  input  wire logic [bgcr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [bgcr_pkg::COORD_W-1:0]     cfg_data
);
  import bgcr_pkg::*;

  logic signed [COORD_W-1:0] wl_r, wr_r, wt_r, wb_r;
  logic [DIM_W-1:0]          rows_r, cols_r;
  logic signed [COORD_W:0]   wd, hd;
  world_t                    world;

  logic              fjob_valid, q_full, q_nempty, q_pop, q_push;
  job_t              fjob, qhead;
  logic [QCNT_W-1:0] q_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= '0;
      wr_r   <= COORD_W'(65536);
      wt_r   <= COORD_W'(65536);
      wb_r   <= '0;
      rows_r <= DIM_W'(1);
      cols_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_WORLD_LEFT:   wl_r   <= cfg_data;
        CFG_WORLD_RIGHT:  wr_r   <= cfg_data;
        CFG_WORLD_TOP:    wt_r   <= cfg_data;
        CFG_WORLD_BOTTOM: wb_r   <= cfg_data;
        CFG_GRID_ROWS:    rows_r <= cfg_data[DIM_W-1:0];
        CFG_GRID_COLS:    cols_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wd          = sdiff(wr_r, wl_r);
    hd          = sdiff(wt_r, wb_r);
    world.wl    = wl_r;
    world.wr    = wr_r;
    world.wt    = wt_r;
    world.wb    = wb_r;
    world.w     = wd[COORD_W-1:0];
    world.h     = hd[COORD_W-1:0];
    world.nrows = grid_dim(rows_r, MAXD_W'(MAX_GRID_DIM));
    world.ncols = grid_dim(cols_r, MAXD_W'(MAX_GRID_DIM));
    world.bad   = wd[COORD_W] || (wd == '0) || hd[COORD_W] || (hd == '0);
  end

  bgcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_box    (in_box),
    .world     (world),
    .q_full    (q_full),
    .job_valid (fjob_valid),
    .job       (fjob)
  );

  assign q_push = fjob_valid && !q_full;

  bgcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (fjob),
    .pop       (q_pop),
    .full      (q_full),
    .nempty    (q_nempty),
    .head      (qhead),
    .cnt       (q_cnt)
  );

  bgcr_back #(
    .MAX_GRID_DIM (MAX_GRID_DIM)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_nempty),
    .job       (qhead),
    .world     (world),
    .pop       (q_pop),
    .out_res   (out_res)
  );

  `BGCR_ASSERT_IMP(a_bad_world_zero, out_res.valid && out_res.world_invalid, (out_res.first_row == '0) && (out_res.last_row == '0) && (out_res.first_col == '0) && (out_res.last_col == '0))
  `BGCR_ASSERT_IMP(a_queue_bound, 1'b1, q_cnt <= QCNT_W'(QDEPTH))
  `BGCR_ASSERT_IMP(a_queue_no_overrun, q_push && !q_pop, q_cnt < QCNT_W'(QDEPTH))
  `BGCR_ASSERT_NXT(a_pop_drains, q_pop && !q_push, q_cnt == $past(q_cnt) - QCNT_W'(1))
endmodule
`default_nettype wire

FILE: bench/bgcr_range_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bgcr_range_checker
// watches the box, result and register ports of the grid cell range unit,
// works out the cell range of every accepted box and compares it with the
// result beats in order
// ----------------------------------------------------------------------------
`default_nettype none
module bgcr_range_checker
  import bgcr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bgcr_in_if                        box_ch,
  bgcr_out_if                       res_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [COORD_W-1:0]   cfg_data,
  output int                        n_fail,
  output int                        n_pending
);

  localparam longint GRID_MAX = DEF_MAX_GRID_DIM;

  typedef struct packed {
    logic [IDX_W-1:0] first_row;
    logic [IDX_W-1:0] last_row;
    logic [IDX_W-1:0] first_col;
    logic [IDX_W-1:0] last_col;
    logic             world_invalid;
  } cell_range_t;

  logic signed [COORD_W-1:0] w_left, w_right, w_top, w_bottom;
  logic [DIM_W-1:0]          rows_reg, cols_reg;
  cell_range_t               range_q[$];

  function automatic longint dim_used(input logic [DIM_W-1:0] v);
    longint d;
    d = longint'(v);
    if (d == 0) d = 1;
    if (d > GRID_MAX) d = GRID_MAX;
    return d;
  endfunction

  function automatic longint floor_div(input longint n, input longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint ceil_div(input longint n, input longint d);
    if (n >= 0) return (n + d - 1) / d;
    return -((-n) / d);
  endfunction

  // offset limited to the extent, then floor for a first index, ceil-1 for a last
  function automatic logic [IDX_W-1:0] edge_cell(input longint off, input longint extent,
                                                 input longint n, input bit upper);
    longint v;
    if (off > extent) off = extent;
    if (upper) v = ceil_div(off * n, extent) - 1;
    else v = floor_div(off * n, extent);
    if (v < 0) v = 0;
    if (v >= n) v = n - 1;
    return IDX_W'(v);
  endfunction

  function automatic cell_range_t bin_box(input longint bl, input longint br,
                                          input longint bt, input longint bb);
    cell_range_t r;
    longint wl, wr, wt, wb, w, h, nr, nc;
    wl = longint'(w_left);
    wr = longint'(w_right);
    wt = longint'(w_top);
    wb = longint'(w_bottom);
    w = wr - wl;
    h = wt - wb;
    nr = dim_used(rows_reg);
    nc = dim_used(cols_reg);
    r = '0;
    if (w <= 0 || h <= 0) begin
      r.world_invalid = 1'b1;
      return r;
    end
    if (bt > wt) bt = wt;
    if (bb < wb) bb = wb;
    if (br > wr) br = wr;
    if (bl < wl) bl = wl;
    r.first_row = edge_cell(wt - bt, h, nr, 1'b0);
    r.last_row  = edge_cell(wt - bb, h, nr, 1'b1);
    r.first_col = edge_cell(bl - wl, w, nc, 1'b0);
    r.last_col  = edge_cell(br - wl, w, nc, 1'b1);
    return r;
  endfunction

  assign n_pending = range_q.size();

  initial n_fail = 0;

  always @(posedge clk) begin
    cell_range_t got, want;
    if (!rst_n) begin
      w_left   <= '0;
      w_right  <= 32'sd65536;
      w_top    <= 32'sd65536;
      w_bottom <= '0;
      rows_reg <= DIM_W'(1);
      cols_reg <= DIM_W'(1);
      range_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_WORLD_LEFT:   w_left   <= cfg_data;
          CFG_WORLD_RIGHT:  w_right  <= cfg_data;
          CFG_WORLD_TOP:    w_top    <= cfg_data;
          CFG_WORLD_BOTTOM: w_bottom <= cfg_data;
          CFG_GRID_ROWS:    rows_reg <= cfg_data[DIM_W-1:0];
          CFG_GRID_COLS:    cols_reg <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (box_ch.valid && box_ch.ready)
        range_q.insert(range_q.size(),
                       bin_box(longint'(box_ch.box_left), longint'(box_ch.box_right),
                               longint'(box_ch.box_top), longint'(box_ch.box_bottom)));
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.first_row, res_ch.last_row, res_ch.first_col, res_ch.last_col,
                res_ch.world_invalid};
        if (range_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("result beat with no box outstanding: %p", got);
        end else begin
          want = range_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// box to grid cell range unit bench: directed edge boxes, then random boxes
// over a series of world and grid settings, with random gaps and stalls
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import bgcr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [COORD_W-1:0]   cfg_data = '0;
  int n_fail, n_pending;
  int cyc = 0;
  int hold_off = 0;
  bit no_idle = 1'b0;

  longint wl = 0, wr = 65536, wt = 65536, wb = 0;

  bgcr_in_if  box_if();
  bgcr_out_if res_if();

  box_to_grid_cell_range_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_box(box_if), .out_res(res_if),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  bgcr_range_checker u_chk (
    .clk(clk), .rst_n(rst_n), .box_ch(box_if), .res_ch(res_if),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .n_fail(n_fail), .n_pending(n_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) res_if.ready <= 1'b0;
    else if (hold_off > 0) begin
      res_if.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (no_idle) res_if.ready <= 1'b1;
    else res_if.ready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                         ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
  end

  initial begin
    box_if.valid = 1'b0;
    box_if.box_left = '0;
    box_if.box_right = '0;
    box_if.box_top = '0;
    box_if.box_bottom = '0;
    res_if.ready = 1'b0;
  end

  task automatic send_box(input longint l, input longint r, input longint t, input longint b);
    int g;
    g = gap_len();
    if (g > 0) begin
      box_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    box_if.valid      <= 1'b1;
    box_if.box_left   <= COORD_W'(l);
    box_if.box_right  <= COORD_W'(r);
    box_if.box_top    <= COORD_W'(t);
    box_if.box_bottom <= COORD_W'(b);
    do @(negedge clk); while (!box_if.ready);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    box_if.valid <= 1'b0;
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= COORD_W'(val);
    @(posedge clk);
  endtask

  task automatic set_world(input longint l, input longint r, input longint t, input longint b,
                           input int rows, input int cols);
    wait_drained();
    write_reg(CFG_WORLD_LEFT, l);
    write_reg(CFG_WORLD_RIGHT, r);
    write_reg(CFG_WORLD_TOP, t);
    write_reg(CFG_WORLD_BOTTOM, b);
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_SPARE, $urandom);
    cfg_we <= 1'b0;
    wl = longint'(signed'(COORD_W'(l)));
    wr = longint'(signed'(COORD_W'(r)));
    wt = longint'(signed'(COORD_W'(t)));
    wb = longint'(signed'(COORD_W'(b)));
  endtask

  // coordinate near the span lo..hi, sometimes a bit past either end
  function automatic longint pick(input longint lo, input longint hi);
    longint span, v;
    span = (hi > lo) ? hi - lo : 65536;
    v = lo + ({$urandom, $urandom} % (span + 1));
    if ($urandom_range(0, 9) == 0) v = v + longint'($urandom_range(0, 1) ? 1 : -1) *
                                          ({$urandom, $urandom} % (span / 4 + 2));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  task automatic random_box();
    int mode;
    longint a, b, c, d, x;
    mode = $urandom_range(0, 99);
    if (mode < 12) begin
      send_box(signed'($urandom), signed'($urandom), signed'($urandom), signed'($urandom));
    end else begin
      a = pick(wl, wr); b = pick(wl, wr);
      c = pick(wb, wt); d = pick(wb, wt);
      // mostly well-ordered boxes, a few inverted
      if (mode < 90) begin
        if (a > b) begin x = a; a = b; b = x; end
        if (d > c) begin x = c; c = d; d = x; end
      end
      send_box(a, b, c, d);
    end
  endtask

  task automatic random_run(input int n);
    repeat (n) random_box();
  endtask

  localparam longint SMIN = -64'sd2147483648;
  localparam longint SMAX = 64'sd2147483647;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default world, unit square with one cell
    send_box(0, 65536, 65536, 0);
    send_box(SMIN, SMAX, SMAX, SMIN);
    send_box(32768, 32768, 32768, 32768);
    send_box(65536, 0, 0, 65536);
    send_box(SMAX, SMAX, SMIN, SMIN);
    send_box(-1, -1, -1, -1);

    set_world(SMIN, SMAX, SMAX, SMIN, 4096, 4096);
    send_box(SMIN, SMAX, SMAX, SMIN);
    send_box(0, 0, 0, 0);
    send_box(SMIN, SMIN, SMIN, SMIN);
    send_box(SMAX, SMAX, SMAX, SMAX);
    send_box(SMAX, SMIN, SMIN, SMAX);
    send_box(-65536, 65536, 65536, -65536);

    // grid of zero and above the maximum
    set_world(-10 * 65536, 20 * 65536, 7 * 65536, -3 * 65536, 0, 8191);
    send_box(-10 * 65536, 20 * 65536, 7 * 65536, -3 * 65536);
    send_box(0, 1, 1, 0);
    send_box(-11 * 65536, -10 * 65536, 9 * 65536, 8 * 65536);
    send_box(21 * 65536, 30 * 65536, -4 * 65536, -9 * 65536);

    // invalid worlds: zero width, then negative height
    set_world(65536, 65536, 65536, 0, 3, 3);
    send_box(0, 65536, 65536, 0);
    send_box(SMIN, SMAX, SMAX, SMIN);
    set_world(0, 65536, 0, 65536, 3, 3);
    send_box(0, 65536, 65536, 0);
    send_box(12345, 54321, 1, 2);

    set_world(0, 10 * 65536, 10 * 65536, 0, 10, 10);
    random_run(150);
    // long hold-off on the result side while boxes keep coming
    hold_off <= 400;
    random_run(80);
    wait_drained();
    random_run(60);

    set_world(-5 * 65536 + 123, 3 * 65536 + 7, 65536, -65536 - 99, 7, 13);
    random_run(180);
    set_world(SMIN, SMAX, SMAX, SMIN, 4096, 4096);
    random_run(180);
    set_world(-3, 5, 2, -1, 4096, 3000);
    random_run(150);
    set_world(100, 101, 101, 100, 1, 4096);
    random_run(120);
    // one stretch with no gaps or stalls
    set_world(-1000 * 65536, 1000 * 65536, 0, -500 * 65536, 4095, 17);
    no_idle = 1'b1;
    random_run(150);
    no_idle = 1'b0;
    set_world(0, 65536, SMAX, SMIN, $urandom_range(1, 4096), $urandom_range(4097, 8191));
    random_run(150);
    set_world(SMAX, SMIN, 10, 0, 5, 5);
    random_run(40);
    set_world(signed'($urandom) >>> 1, 32'h7000_0000, 32'h1000_0000, -32'sh1000_0000,
              $urandom_range(1, 64), $urandom_range(1, 64));
    random_run(150);

    wait_drained();
    if (n_fail == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/bgcr_pkg.sv
rtl/bgcr_in_if.sv
rtl/bgcr_out_if.sv
rtl/bgcr_front.sv
rtl/bgcr_queue.sv
rtl/bgcr_back.sv
rtl/box_to_grid_cell_range_unit.sv
bench/bgcr_range_checker.sv
bench/tb.sv
